// ----- rtl/rgbhsv_pkg.sv -----
// package: widths, stage payload types and the shared divider step
`default_nettype none
package rgbhsv_pkg;

	localparam int CHANNEL_BITS = 8;
	localparam int CW           = CHANNEL_BITS;
	localparam int FULL         = (1 << CW) - 1;

	localparam int HUE_BITS   = 13;
	localparam int HUE_SECTOR = 960;
	localparam int HUE_CIRCLE = 5760;
	// bits of the hue quotient, which never exceeds one sector
	localparam int SECTOR_QB  = $clog2(HUE_SECTOR + 1);

	// both dividers run the same number of restoring steps, two per stage
	localparam int DIV_RAW    = (CW > SECTOR_QB) ? CW : SECTOR_QB;
	localparam int DIV_STEPS  = ((DIV_RAW + 1) / 2) * 2;
	localparam int DIV_STAGES = DIV_STEPS / 2;
	localparam int NUM_W      = DIV_STEPS + CW;

	typedef enum logic [1:0] {
		SEC_RED   = 2'd0,
		SEC_GREEN = 2'd1,
		SEC_BLUE  = 2'd2
	} sector_t;

	// one restoring divider lane: remaining dividend bits, partial remainder
	typedef struct packed {
		logic [DIV_STEPS-1:0] num;
		logic [CW-1:0]        rem;
		logic [CW-1:0]        den;
		logic [DIV_STEPS-1:0] quo;
	} div_lane_t;

	typedef struct packed {
		div_lane_t     hue_div;
		div_lane_t     sat_div;
		sector_t       sector;
		logic          diff_neg;
		logic [CW-1:0] brightness;
		logic          undef;
	} pipe_t;

	function automatic div_lane_t div_step(input div_lane_t l);
		div_lane_t  r;
		logic [CW:0] t;
		logic [CW:0] t_sub;
		r     = l;
		t     = {l.rem, l.num[DIV_STEPS-1]};
		t_sub = t - {1'b0, l.den};
		r.num = l.num << 1;
		if (t >= {1'b0, l.den}) begin
			r.rem = t_sub[CW-1:0];
			r.quo = {l.quo[DIV_STEPS-2:0], 1'b1};
		end else begin
			r.rem = t[CW-1:0];
			r.quo = {l.quo[DIV_STEPS-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/rgbhsv_if.sv -----
// stream interfaces for rgb input items and hsv result items
`default_nettype none
interface rgbhsv_rgb_if;
	import rgbhsv_pkg::*;
	logic          valid;
	logic          ready;
	logic [CW-1:0] red;
	logic [CW-1:0] green;
	logic [CW-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhsv_hsv_if;
	import rgbhsv_pkg::*;
	logic                valid;
	logic                ready;
	logic [HUE_BITS-1:0] hue;
	logic [CW-1:0]       saturation;
	logic [CW-1:0]       brightness;
	logic                hue_undefined;

	modport source (output valid, output hue, output saturation, output brightness,
		output hue_undefined, input ready);
	modport sink   (input valid, input hue, input saturation, input brightness,
		input hue_undefined, output ready);
endinterface
`default_nettype wire

// ----- rtl/rgbhsv_front.sv -----
// first stage: max, min, delta, sector select and divider setup
`default_nettype none
module rgbhsv_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	rgbhsv_rgb_if.sink           pixel_in,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output rgbhsv_pkg::pipe_t    out_data
);
	import rgbhsv_pkg::*;

	logic [CW-1:0]    mx_rg, mn_rg, mx, mn, delta, mag;
	logic [CW:0]      diff;
	logic [NUM_W-1:0] hue_num, sat_num;
	sector_t          sector;
	pipe_t            nxt;
	logic             valid_s1;
	pipe_t            data_s1;

	always_comb begin
		mx_rg = (pixel_in.green > pixel_in.red) ? pixel_in.green : pixel_in.red;
		mx    = (pixel_in.blue > mx_rg) ? pixel_in.blue : mx_rg;
		mn_rg = (pixel_in.green < pixel_in.red) ? pixel_in.green : pixel_in.red;
		mn    = (pixel_in.blue < mn_rg) ? pixel_in.blue : mn_rg;
		delta = mx - mn;

		// red wins ties, then green
		if (pixel_in.red == mx) begin
			sector = SEC_RED;
			diff   = {1'b0, pixel_in.green} - {1'b0, pixel_in.blue};
		end else if (pixel_in.green == mx) begin
			sector = SEC_GREEN;
			diff   = {1'b0, pixel_in.blue} - {1'b0, pixel_in.red};
		end else begin
			sector = SEC_BLUE;
			diff   = {1'b0, pixel_in.red} - {1'b0, pixel_in.green};
		end
		mag = diff[CW] ? CW'(-diff) : diff[CW-1:0];

		hue_num = NUM_W'(mag) * NUM_W'(HUE_SECTOR);
		sat_num = NUM_W'(delta) * NUM_W'(FULL);

		nxt.hue_div.num = hue_num[DIV_STEPS-1:0];
		nxt.hue_div.rem = hue_num[NUM_W-1:DIV_STEPS];
		nxt.hue_div.den = delta;
		nxt.hue_div.quo = '0;
		nxt.sat_div.num = sat_num[DIV_STEPS-1:0];
		nxt.sat_div.rem = sat_num[NUM_W-1:DIV_STEPS];
		nxt.sat_div.den = mx;
		nxt.sat_div.quo = '0;
		nxt.sector      = sector;
		nxt.diff_neg    = diff[CW];
		nxt.brightness  = mx;
		nxt.undef       = (delta == '0);
	end

	assign pixel_in.ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel_in.ready) begin
			valid_s1 <= pixel_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel_in.ready && pixel_in.valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule
`default_nettype wire

// ----- rtl/rgbhsv_div_stage.sv -----
// divider stage: two restoring steps for both the hue and saturation lanes
`default_nettype none
module rgbhsv_div_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire rgbhsv_pkg::pipe_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output rgbhsv_pkg::pipe_t       out_data
);
	import rgbhsv_pkg::*;

	pipe_t nxt;
	logic  valid_q;
	pipe_t data_q;

	always_comb begin
		nxt         = in_data;
		nxt.hue_div = div_step(div_step(in_data.hue_div));
		nxt.sat_div = div_step(div_step(in_data.sat_div));
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule
`default_nettype wire

// ----- rtl/rgbhsv_back.sv -----
// last stage: hue assembly from sector and quotient, output register
`default_nettype none
module rgbhsv_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire rgbhsv_pkg::pipe_t  in_data,
	rgbhsv_hsv_if.source            pixel_out
);
	import rgbhsv_pkg::*;

	logic [HUE_BITS-1:0] q, base, hue_nxt;
	logic                rem_nz;
	logic                valid_q;
	logic [HUE_BITS-1:0] hue_q;
	logic [CW-1:0]       sat_q, bright_q;
	logic                undef_q;

	always_comb begin
		q      = HUE_BITS'(in_data.hue_div.quo[SECTOR_QB-1:0]);
		rem_nz = |in_data.hue_div.rem;
		unique case (in_data.sector)
			SEC_GREEN: base = HUE_BITS'(2 * HUE_SECTOR);
			SEC_BLUE:  base = HUE_BITS'(4 * HUE_SECTOR);
			default:   base = '0;
		endcase
		if (in_data.undef) begin
			hue_nxt = '0;
		end else if (in_data.sector == SEC_RED) begin
			// truncation toward zero, then wrap a negative angle
			if (in_data.diff_neg && q != '0) begin
				hue_nxt = HUE_BITS'(HUE_CIRCLE) - q;
			end else begin
				hue_nxt = q;
			end
		end else if (in_data.diff_neg) begin
			// numerator stays positive here, so a remainder rounds the drop up
			hue_nxt = base - q - HUE_BITS'(rem_nz);
		end else begin
			hue_nxt = base + q;
		end
	end

	assign in_ready = !valid_q || pixel_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			hue_q    <= hue_nxt;
			sat_q    <= in_data.undef ? '0 : in_data.sat_div.quo[CW-1:0];
			bright_q <= in_data.brightness;
			undef_q  <= in_data.undef;
		end
	end

	assign pixel_out.valid         = valid_q;
	assign pixel_out.hue           = hue_q;
	assign pixel_out.saturation    = sat_q;
	assign pixel_out.brightness    = bright_q;
	assign pixel_out.hue_undefined = undef_q;

endmodule
`default_nettype wire

// ----- rtl/rgb_to_hsv_pixel_converter.sv -----
// top level: pipelined rgb to hsv pixel converter
// usage:
//   pixel_in carries one rgb item (red, green, blue, unsigned channels);
//   pixel_out returns one hsv item per input item, in order: hue in
//   sixteenths of a degree (0..5759), saturation, brightness (the largest
//   channel) and hue_undefined for grey or black pixels (hue and saturation 0)
//   an item moves on a rising edge where valid and ready are both high
//   one setup stage, DIV_STAGES divider stages (five with 8-bit channels) of
//   two restoring steps each, one output stage; the divider stages set the depth
//   throughput is one item per cycle while the receiver keeps up
//   every stage has its own valid bit and takes a new item whenever it is
//   empty or its successor moves, so bubbles close up
//   when the receiver stalls, items pile up stage by stage and ready falls
//   only once all stages are full; nothing is dropped or repeated
//   reset (arst_n low, asynchronous) empties the pipeline; payload registers
//   keep whatever they held
`default_nettype none
module rgb_to_hsv_pixel_converter (
	input  wire logic     clk,
	input  wire logic     arst_n,
	rgbhsv_rgb_if.sink    pixel_in,
	rgbhsv_hsv_if.source  pixel_out
);
	import rgbhsv_pkg::*;

	// stage links: entry 0 leaves the setup stage, the last one feeds the output stage
	logic  stage_valid [DIV_STAGES+1];
	logic  stage_ready [DIV_STAGES+1];
	pipe_t stage_data  [DIV_STAGES+1];

	rgbhsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel_in  (pixel_in),
		.out_valid (stage_valid[0]),
		.out_ready (stage_ready[0]),
		.out_data  (stage_data[0])
	);

	// divider chain, two quotient bits per stage for both lanes
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		rgbhsv_div_stage u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stage_valid[k]),
			.in_ready  (stage_ready[k]),
			.in_data   (stage_data[k]),
			.out_valid (stage_valid[k+1]),
			.out_ready (stage_ready[k+1]),
			.out_data  (stage_data[k+1])
		);
	end

	rgbhsv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stage_valid[DIV_STAGES]),
		.in_ready  (stage_ready[DIV_STAGES]),
		.in_data   (stage_data[DIV_STAGES]),
		.pixel_out (pixel_out)
	);

	// an accepted item is held by the setup stage on the next cycle
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_in.valid && pixel_in.ready |=> stage_valid[0])
		else $error("accepted item missing from setup stage");

	// hue stays on the circle
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_out.valid |-> pixel_out.hue < HUE_BITS'(HUE_CIRCLE))
		else $error("hue out of range");

	// grey or black pixels carry zero hue and saturation
	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_out.valid && pixel_out.hue_undefined |->
			pixel_out.hue == '0 && pixel_out.saturation == '0)
		else $error("undefined hue with nonzero hue or saturation");

	// a defined hue needs a nonzero brightness
	a_defined_bright: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_out.valid && !pixel_out.hue_undefined |-> pixel_out.brightness != '0)
		else $error("defined hue on a black pixel");

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// testbench for the rgb to hsv pixel converter: directed corners, random streams, backpressure
`default_nettype none
module tb;
	import rgbhsv_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 20;
	localparam int LONG_HOLD     = 300;

	typedef struct packed {
		logic [CW-1:0] red;
		logic [CW-1:0] green;
		logic [CW-1:0] blue;
	} rgb_pixel_t;

	typedef struct packed {
		logic [HUE_BITS-1:0] hue;
		logic [CW-1:0]       saturation;
		logic [CW-1:0]       brightness;
		logic                hue_undefined;
	} hsv_result_t;

	typedef enum int {
		RX_OPEN,
		RX_SPARSE_STALL,
		RX_HALF,
		RX_PERIODIC
	} rx_mode_t;

	logic clk;
	logic arst_n;

	rgbhsv_rgb_if rgb_if ();
	rgbhsv_hsv_if hsv_if ();

	hsv_result_t expected_hsv_q [$];
	int          mismatch_count = 0;
	int          cycle_count    = 0;
	int          hold_cycles_req = 0;
	bit          rx_free = 1'b0;

	rgb_to_hsv_pixel_converter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel_in  (rgb_if),
		.pixel_out (hsv_if)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** rgb_to_hsv_pixel_converter: FAILED **");
			$finish;
		end
	end

	// hue in sixteenths of a degree, sector picked red first, then green
	function automatic hsv_result_t predict_hsv(input rgb_pixel_t p);
		hsv_result_t res;
		int r, g, b, mx, mn, delta, sector, diff, h;
		r  = int'(p.red);
		g  = int'(p.green);
		b  = int'(p.blue);
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		delta = mx - mn;
		res.brightness = mx[CW-1:0];
		if (delta == 0) begin
			res.hue           = '0;
			res.saturation    = '0;
			res.hue_undefined = 1'b1;
		end else begin
			res.saturation = CW'((delta * FULL) / mx);
			if (r == mx) begin
				sector = 0;
				diff   = g - b;
			end else if (g == mx) begin
				sector = 2;
				diff   = b - r;
			end else begin
				sector = 4;
				diff   = r - g;
			end
			h = ((sector * delta + diff) * HUE_SECTOR) / delta;
			if (h < 0)
				h += HUE_CIRCLE;
			res.hue           = h[HUE_BITS-1:0];
			res.hue_undefined = 1'b0;
		end
		return res;
	endfunction

	function automatic rgb_pixel_t pixel(input int r, input int g, input int b);
		rgb_pixel_t p;
		p.red   = r[CW-1:0];
		p.green = g[CW-1:0];
		p.blue  = b[CW-1:0];
		return p;
	endfunction

	// mix of greys, ties, extremes and close colors on top of plain random
	function automatic rgb_pixel_t random_pixel();
		int v, m, lo, slot;
		case ($urandom_range(0, 9))
			0: begin
				v = $urandom_range(0, FULL);
				return pixel(v, v, v);
			end
			1: return pixel($urandom_range(0, 1) * FULL, $urandom_range(0, 1) * FULL,
				$urandom_range(0, 1) * FULL);
			2: begin
				m    = $urandom_range(1, FULL);
				lo   = $urandom_range(0, m - 1);
				slot = $urandom_range(0, 2);
				if (slot == 0) return pixel(lo, m, m);
				if (slot == 1) return pixel(m, lo, m);
				return pixel(m, m, lo);
			end
			3: begin
				v = $urandom_range(2, FULL - 2);
				return pixel(v + $urandom_range(0, 2) - 1, v + $urandom_range(0, 2) - 1,
					v + $urandom_range(0, 2) - 1);
			end
			default: return pixel($urandom_range(0, FULL), $urandom_range(0, FULL),
				$urandom_range(0, FULL));
		endcase
	endfunction

	// offer one item from the falling edge until it is taken
	task automatic send_pixel(input rgb_pixel_t p);
		@(negedge clk);
		rgb_if.valid <= 1'b1;
		rgb_if.red   <= p.red;
		rgb_if.green <= p.green;
		rgb_if.blue  <= p.blue;
		do
			@(posedge clk);
		while (rgb_if.ready !== 1'b1);
	endtask

	task automatic idle_sender(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			rgb_if.valid <= 1'b0;
			rgb_if.red   <= CW'($urandom);
			rgb_if.green <= CW'($urandom);
			rgb_if.blue  <= CW'($urandom);
		end
	endtask

	task automatic wait_results_drained();
		idle_sender(1);
		while (expected_hsv_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_corner_pixels();
		send_pixel(pixel(0, 0, 0));
		send_pixel(pixel(FULL, FULL, FULL));
		send_pixel(pixel(128, 128, 128));
		send_pixel(pixel(1, 1, 1));
		send_pixel(pixel(FULL, 0, 0));
		send_pixel(pixel(0, FULL, 0));
		send_pixel(pixel(0, 0, FULL));
		send_pixel(pixel(FULL, FULL, 0));
		send_pixel(pixel(0, FULL, FULL));
		send_pixel(pixel(FULL, 0, FULL));
		send_pixel(pixel(FULL, 0, 1));
		send_pixel(pixel(200, FULL, 0));
		send_pixel(pixel(0, 1, FULL));
		send_pixel(pixel(1, 0, 0));
		send_pixel(pixel(0, 1, 0));
		send_pixel(pixel(0, 0, 1));
		send_pixel(pixel(FULL, FULL - 1, FULL - 1));
		send_pixel(pixel(FULL - 1, FULL, FULL - 1));
		send_pixel(pixel(FULL - 1, FULL - 1, FULL));
		send_pixel(pixel(FULL, 1, 0));
		send_pixel(pixel(170, 85, FULL));
		wait_results_drained();
	endtask

	task automatic test_random_bursts(input int total);
		int sent, len;
		sent = 0;
		while (sent < total) begin
			len = $urandom_range(1, 24);
			repeat (len) begin
				send_pixel(random_pixel());
				sent++;
			end
			if ($urandom_range(0, 3) == 0)
				idle_sender($urandom_range(5, 20));
			else
				idle_sender($urandom_range(0, 6));
		end
		wait_results_drained();
	endtask

	// receiver holds off while the sender keeps offering, so the pipeline fills
	task automatic test_output_hold_fill();
		@(posedge clk);
		hold_cycles_req = LONG_HOLD;
		repeat (60)
			send_pixel(random_pixel());
		wait_results_drained();
	endtask

	task automatic test_back_to_back();
		@(posedge clk);
		rx_free = 1'b1;
		repeat (250)
			send_pixel(random_pixel());
		wait_results_drained();
		rx_free = 1'b0;
	endtask

	// receiver: random stall modes, a long hold on request, or always ready
	initial begin : result_receiver
		rx_mode_t mode;
		int       mode_left;
		int       hold_left;
		int       phase;
		hsv_if.ready = 1'b0;
		mode         = RX_OPEN;
		mode_left    = 0;
		hold_left    = 0;
		phase        = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles_req != 0) begin
				hold_left       = hold_cycles_req;
				hold_cycles_req = 0;
			end
			if (mode_left == 0) begin
				mode      = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			phase++;
			if (hold_left != 0) begin
				hold_left--;
				hsv_if.ready <= 1'b0;
			end else if (rx_free) begin
				hsv_if.ready <= 1'b1;
			end else begin
				case (mode)
					RX_OPEN:         hsv_if.ready <= 1'b1;
					RX_SPARSE_STALL: hsv_if.ready <= ($urandom_range(0, 3) != 0);
					RX_HALF:         hsv_if.ready <= ($urandom_range(0, 1) == 1);
					RX_PERIODIC:     hsv_if.ready <= ((phase % 7) > 2);
					default:         hsv_if.ready <= 1'b1;
				endcase
			end
		end
	end

	// results are checked before this edge's accepted input is predicted
	always @(posedge clk) begin : hsv_scoreboard
		hsv_result_t got;
		hsv_result_t want;
		string       want_str;
		if (arst_n) begin
			if (hsv_if.valid === 1'b1 && hsv_if.ready === 1'b1) begin
				got.hue           = hsv_if.hue;
				got.saturation    = hsv_if.saturation;
				got.brightness    = hsv_if.brightness;
				got.hue_undefined = hsv_if.hue_undefined;
				if (expected_hsv_q.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected item hue %0d sat %0d val %0d undef %0b", $time,
						got.hue, got.saturation, got.brightness, got.hue_undefined);
				end else begin
					want = expected_hsv_q.pop_front();
					if (got !== want) begin
						mismatch_count++;
						want_str = $sformatf("hue %0d sat %0d val %0d undef %0b",
							want.hue, want.saturation, want.brightness, want.hue_undefined);
						$display("%0t: expected %s, actual hue %0d sat %0d val %0d undef %0b",
							$time, want_str, got.hue, got.saturation, got.brightness,
							got.hue_undefined);
					end
				end
			end
			if (rgb_if.valid === 1'b1 && rgb_if.ready === 1'b1)
				expected_hsv_q = {expected_hsv_q, predict_hsv(pixel(rgb_if.red,
					rgb_if.green, rgb_if.blue))};
		end
	end

	initial begin
		arst_n       = 1'b0;
		rgb_if.valid = 1'b0;
		rgb_if.red   = '0;
		rgb_if.green = '0;
		rgb_if.blue  = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_corner_pixels();
		test_random_bursts(700);
		test_output_hold_fill();
		test_back_to_back();
		test_random_bursts(700);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_hsv_q.size() == 0) begin
			$display("** rgb_to_hsv_pixel_converter: PASSED **");
		end else begin
			$display("** rgb_to_hsv_pixel_converter: FAILED **");
		end
		$finish;
	end

endmodule
`default_nettype wire
